// ===== sv/binary_max_heap_queue_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the binary max-heap queue
// Shared forms for the concurrent checks of the block, same cycle and next cycle.
// ----------------------------------------------------------------------------
`ifndef BINARY_MAX_HEAP_QUEUE_TOP_ASSERT_SVH
`define BINARY_MAX_HEAP_QUEUE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BHQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BHQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bhq_pkg.sv =====
// ----------------------------------------------------------------------------
// Binary max-heap queue package
// Entry layout, ranking rule, microcode codes and the control store.
// ----------------------------------------------------------------------------
package bhq_pkg;

    localparam int KEY_W   = 16;
    localparam int TAG_W   = 10;
    localparam int STEP_W  = 4;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_entry;

    typedef logic [STEP_W-1:0] t_step;

    typedef enum logic [3:0] {
        U_NOP,
        U_LATCH,
        U_DROP,
        U_EMPTY,
        U_INS_INIT,
        U_UP_STEP,
        U_RD_ENDS,
        U_EXT_INIT,
        U_DN_STEP,
        U_WR_CUR,
        U_REPLY
    } t_uop;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_BEAT,
        C_EXTRACT,
        C_FULL,
        C_COUNT_ZERO,
        C_UP_MORE,
        C_OUT_BUSY,
        C_FEW,
        C_DN_MORE
    } t_cond;

    typedef struct packed {
        t_uop  op;
        t_cond cond;
        t_step target;
    } t_uword;

    typedef struct packed {
        logic beat;
        logic extract;
        logic full;
        logic count_zero;
        logic up_more;
        logic out_busy;
        logic few;
        logic dn_more;
    } t_flags;

    localparam t_step S_WAIT     = 4'd0;
    localparam t_step S_DISP     = 4'd1;
    localparam t_step S_INS      = 4'd2;
    localparam t_step S_INS_INIT = 4'd3;
    localparam t_step S_UP       = 4'd4;
    localparam t_step S_END      = 4'd5;
    localparam t_step S_REPLY    = 4'd6;
    localparam t_step S_BACK     = 4'd7;
    localparam t_step S_EXT      = 4'd8;
    localparam t_step S_EXT_RD   = 4'd9;
    localparam t_step S_EXT_TOP  = 4'd10;
    localparam t_step S_DN       = 4'd11;
    localparam t_step S_DN_OUT   = 4'd12;
    localparam t_step S_DROP     = 4'd13;
    localparam t_step S_EMPTY    = 4'd14;

    // A ranks above B on a higher key, or on an equal key with a lower tag.
    function automatic logic f_ranks_above(input t_entry a, input t_entry b);
        logic res;
        if (a.key != b.key) begin
            res = (a.key > b.key);
        end else begin
            res = (a.tag < b.tag);
        end
        return res;
    endfunction

    // Control store: a jump to the target is taken when the condition holds.
    function automatic t_uword f_urom(input t_step step);
        t_uword w;
        case (step)
            S_WAIT:     w = '{U_LATCH,    C_NO_BEAT,    S_WAIT};
            S_DISP:     w = '{U_NOP,      C_EXTRACT,    S_EXT};
            S_INS:      w = '{U_NOP,      C_FULL,       S_DROP};
            S_INS_INIT: w = '{U_INS_INIT, C_COUNT_ZERO, S_END};
            S_UP:       w = '{U_UP_STEP,  C_UP_MORE,    S_UP};
            S_END:      w = '{U_WR_CUR,   C_NEVER,      S_WAIT};
            S_REPLY:    w = '{U_REPLY,    C_OUT_BUSY,   S_REPLY};
            S_BACK:     w = '{U_NOP,      C_ALWAYS,     S_WAIT};
            S_EXT:      w = '{U_NOP,      C_COUNT_ZERO, S_EMPTY};
            S_EXT_RD:   w = '{U_RD_ENDS,  C_NEVER,      S_WAIT};
            S_EXT_TOP:  w = '{U_EXT_INIT, C_FEW,        S_END};
            S_DN:       w = '{U_DN_STEP,  C_DN_MORE,    S_DN};
            S_DN_OUT:   w = '{U_NOP,      C_ALWAYS,     S_END};
            S_DROP:     w = '{U_DROP,     C_ALWAYS,     S_REPLY};
            S_EMPTY:    w = '{U_EMPTY,    C_ALWAYS,     S_REPLY};
            default:    w = '{U_NOP,      C_ALWAYS,     S_WAIT};
        endcase
        return w;
    endfunction

endpackage

// ===== sv/binary_max_heap_queue_top.sv =====
// Sequence: an insert is checked for a full heap, then sifts up from the new last slot (the sift-up
// is skipped on an empty heap); an extract with at most one entry left skips the sift-down, else
// it sifts down from the root; a refused insert or an empty extract goes straight to the reply step.
// Flow: a new beat is taken only in the wait step, after the result has loaded and the sequencer has
// passed its return step; a stalled result register holds the sequencer in its reply step.
// Reset: synchronous, clears the entry count, sequencer and output valid; heap memory is not cleared.
// ----------------------------------------------------------------------------
// Binary max-heap queue
// Bounded priority queue: insert sifts up, extract moves the last entry to the
// root and sifts down, driven by a microcoded sequencer.
// ----------------------------------------------------------------------------
`include "binary_max_heap_queue_top_assert.svh"

module binary_max_heap_queue_top #(
    parameter  int CAPACITY = 1024,
    localparam int AW       = $clog2(CAPACITY),
    localparam int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_command,
    input  logic [bhq_pkg::KEY_W-1:0] i_key,
    input  logic [bhq_pkg::TAG_W-1:0] i_tag,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [bhq_pkg::KEY_W-1:0] o_out_key,
    output logic [bhq_pkg::TAG_W-1:0] o_out_tag,
    output logic                      o_was_empty,
    output logic                      o_dropped_full,
    output logic [CW-1:0]             o_entry_count
);
    import bhq_pkg::*;

    localparam int            IW    = AW + 2;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    function automatic logic [AW-1:0] f_parent(input logic [AW-1:0] p);
        logic [AW-1:0] d;
        d = p - AW'(1);
        return d >> 1;
    endfunction

    function automatic logic [IW-1:0] f_left(input logic [AW-1:0] p);
        return {1'b0, p, 1'b1};
    endfunction

    t_uword w_ctl;
    t_flags w_flags;

    t_entry r_mem [CAPACITY];

    logic          r_cmd;
    t_entry        r_new;
    t_entry        r_cur;
    t_entry        n_cur;
    logic [AW-1:0] r_pos;
    logic [AW-1:0] n_pos;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    t_entry        r_rd_a;
    t_entry        r_rd_b;

    logic [KEY_W-1:0] r_res_key;
    logic [TAG_W-1:0] r_res_tag;
    logic             r_res_empty;
    logic             r_res_dropped;

    logic             r_out_valid;
    logic [KEY_W-1:0] r_o_key;
    logic [TAG_W-1:0] r_o_tag;
    logic             r_o_empty;
    logic             r_o_dropped;
    logic [CW-1:0]    r_o_count;

    logic          w_beat;
    logic          w_out_busy;
    logic          w_load_out;
    logic          w_up_move;
    logic [AW-1:0] w_up_parent;
    logic [IW-1:0] w_left;
    logic [IW-1:0] w_right;
    logic [IW-1:0] w_cnt_ext;
    logic          w_a_over_cur;
    logic          w_b_over_cur;
    logic          w_b_over_a;
    logic          w_take_right;
    logic          w_dn_move;
    t_entry        w_best;
    logic [AW-1:0] w_best_idx;
    logic [IW-1:0] w_best_left;
    logic [IW-1:0] w_best_right;
    logic [IW-1:0] w_root_left;
    logic [CW-1:0] w_last;

    logic          w_we;
    t_entry        w_wdata;
    logic [AW-1:0] w_ra;
    logic [AW-1:0] w_rb;

    bhq_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctl   (w_ctl)
    );

    assign w_beat      = i_in_valid && (w_ctl.op == U_LATCH);
    assign o_in_stall  = (w_ctl.op != U_LATCH);
    assign w_out_busy  = r_out_valid && i_out_stall;
    assign w_load_out  = (w_ctl.op == U_REPLY) && !w_out_busy;

    assign w_up_parent = f_parent(r_pos);
    assign w_up_move   = f_ranks_above(r_cur, r_rd_a);

    assign w_left       = f_left(r_pos);
    assign w_right      = w_left + IW'(1);
    assign w_cnt_ext    = IW'(r_count);
    assign w_a_over_cur = f_ranks_above(r_rd_a, r_cur);
    assign w_b_over_cur = f_ranks_above(r_rd_b, r_cur);
    assign w_b_over_a   = f_ranks_above(r_rd_b, r_rd_a);
    assign w_take_right = (w_right < w_cnt_ext) &&
                          (w_a_over_cur ? w_b_over_a : w_b_over_cur);
    assign w_dn_move    = w_take_right || w_a_over_cur;
    assign w_best       = w_take_right ? r_rd_b : r_rd_a;
    assign w_best_idx   = w_take_right ? w_right[AW-1:0] : w_left[AW-1:0];
    assign w_best_left  = f_left(w_best_idx);
    assign w_best_right = w_best_left + IW'(1);
    assign w_root_left  = f_left('0);
    assign w_last       = r_count - CW'(1);

    always_comb begin
        w_flags.beat       = w_beat;
        w_flags.extract    = r_cmd;
        w_flags.full       = (r_count == CAP_C);
        w_flags.count_zero = (r_count == '0);
        w_flags.up_more    = w_up_move && (w_up_parent != '0);
        w_flags.out_busy   = w_out_busy;
        w_flags.few        = (r_count < CW'(2));
        w_flags.dn_more    = w_dn_move && (w_best_left < w_cnt_ext);
    end

    always_comb begin
        n_pos   = r_pos;
        n_cur   = r_cur;
        n_count = r_count;
        w_we    = 1'b0;
        w_wdata = r_cur;
        w_ra    = w_left[AW-1:0];
        w_rb    = w_right[AW-1:0];
        case (w_ctl.op)
            U_INS_INIT: begin
                n_pos   = r_count[AW-1:0];
                n_cur   = r_new;
                n_count = r_count + CW'(1);
                w_ra    = f_parent(r_count[AW-1:0]);
            end
            U_UP_STEP: begin
                w_ra = f_parent(w_up_parent);
                if (w_up_move) begin
                    w_we    = 1'b1;
                    w_wdata = r_rd_a;
                    n_pos   = w_up_parent;
                end
            end
            U_RD_ENDS: begin
                w_ra    = '0;
                w_rb    = w_last[AW-1:0];
                n_count = w_last;
            end
            U_EXT_INIT: begin
                n_cur = r_rd_b;
                n_pos = '0;
                w_ra  = w_root_left[AW-1:0];
                w_rb  = AW'(w_root_left + IW'(1));
            end
            U_DN_STEP: begin
                w_ra = w_best_left[AW-1:0];
                w_rb = w_best_right[AW-1:0];
                if (w_dn_move) begin
                    w_we    = 1'b1;
                    w_wdata = w_best;
                    n_pos   = w_best_idx;
                end
            end
            U_WR_CUR: begin
                w_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_pos] <= w_wdata;
        end
        r_rd_a <= r_mem[w_ra];
        r_rd_b <= r_mem[w_rb];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_pos <= n_pos;
        case (w_ctl.op)
            U_LATCH: begin
                if (w_beat) begin
                    r_cmd         <= i_command;
                    r_new         <= '{key: i_key, tag: i_tag};
                    r_res_key     <= '0;
                    r_res_tag     <= '0;
                    r_res_empty   <= 1'b0;
                    r_res_dropped <= 1'b0;
                end
            end
            U_DROP: begin
                r_res_dropped <= 1'b1;
            end
            U_EMPTY: begin
                r_res_empty <= 1'b1;
            end
            U_EXT_INIT: begin
                r_res_key <= r_rd_a.key;
                r_res_tag <= r_rd_a.tag;
            end
            default: begin
            end
        endcase
        if (w_load_out) begin
            r_o_key     <= r_res_key;
            r_o_tag     <= r_res_tag;
            r_o_empty   <= r_res_empty;
            r_o_dropped <= r_res_dropped;
            r_o_count   <= r_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_key      = r_o_key;
    assign o_out_tag      = r_o_tag;
    assign o_was_empty    = r_o_empty;
    assign o_dropped_full = r_o_dropped;
    assign o_entry_count  = r_o_count;

    // The count of held entries never passes the capacity.
    `BHQ_ASSERT_SAME(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CAP_C, "count over capacity")
    // An insert that is placed grows the count by exactly one.
    `BHQ_ASSERT_NEXT(a_ins_count, i_clk, i_rst_n, w_ctl.op == U_INS_INIT,
                     r_count == $past(r_count) + CW'(1), "insert count slip")
    // An extract that finds entries shrinks the count by exactly one.
    `BHQ_ASSERT_NEXT(a_ext_count, i_clk, i_rst_n, w_ctl.op == U_RD_ENDS,
                     r_count == $past(r_count) - CW'(1), "extract count slip")
    // A result beat never reports both an empty extract and a dropped insert.
    `BHQ_ASSERT_SAME(a_flags_excl, i_clk, i_rst_n, o_out_valid,
                     !(o_was_empty && o_dropped_full), "conflicting result flags")

endmodule

// ===== sv/bhq_useq.sv =====
// ----------------------------------------------------------------------------
// Binary max-heap queue microsequencer
// Step counter over the control store with conditional jumps on datapath flags.
// ----------------------------------------------------------------------------
module bhq_useq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bhq_pkg::t_flags i_flags,
    output bhq_pkg::t_uword o_ctl
);
    import bhq_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_uword w_word;
    logic   w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

    always_comb begin
        w_word = f_urom(r_step);
        case (w_word.cond)
            C_NEVER:      w_take = 1'b0;
            C_ALWAYS:     w_take = 1'b1;
            C_NO_BEAT:    w_take = !i_flags.beat;
            C_EXTRACT:    w_take = i_flags.extract;
            C_FULL:       w_take = i_flags.full;
            C_COUNT_ZERO: w_take = i_flags.count_zero;
            C_UP_MORE:    w_take = i_flags.up_more;
            C_OUT_BUSY:   w_take = i_flags.out_busy;
            C_FEW:        w_take = i_flags.few;
            C_DN_MORE:    w_take = i_flags.dn_more;
            default:      w_take = 1'b0;
        endcase
        n_step = w_take ? w_word.target : r_step + t_step'(1);
    end

    assign o_ctl = w_word;

endmodule
